FILE: hdl/smrds_pkg.sv
// ----------------------------------------------------------------------------
// smrds_pkg
// Shared types, codes, character tables and the control store of the status
// message rotator.
// ----------------------------------------------------------------------------
package smrds_pkg;

  localparam int KIND_W     = 5;
  localparam int CODE_W     = 5;
  localparam int TEXT_KINDS = 22;
  localparam int PC_W       = 4;

  localparam logic [7:0] DOT_BIT  = 8'h80;
  localparam logic [7:0] SEL_NONE = 8'hFF;

  // Item actions
  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_ROTATE = 2'd2;
  localparam logic [1:0] ACT_SCAN   = 2'd3;

  // Datapath operations
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_PTR_ZERO = 4'd1;
  localparam logic [3:0] OP_PTR_INC  = 4'd2;
  localparam logic [3:0] OP_SHIFT    = 4'd3;
  localparam logic [3:0] OP_REMOVE   = 4'd4;
  localparam logic [3:0] OP_APPEND   = 4'd5;
  localparam logic [3:0] OP_IDX_INC  = 4'd6;
  localparam logic [3:0] OP_IDX_SUB  = 4'd7;
  localparam logic [3:0] OP_LOAD     = 4'd8;
  localparam logic [3:0] OP_SCAN     = 4'd9;

  // Jump conditions
  localparam logic [2:0] CND_NEVER        = 3'd0;
  localparam logic [2:0] CND_CLR_SKIP     = 3'd1;
  localparam logic [2:0] CND_MATCH_OR_END = 3'd2;
  localparam logic [2:0] CND_PTR_END      = 3'd3;
  localparam logic [2:0] CND_SHIFT_END    = 3'd4;
  localparam logic [2:0] CND_SET_SKIP     = 3'd5;
  localparam logic [2:0] CND_EMPTY        = 3'd6;
  localparam logic [2:0] CND_IDX_LT       = 3'd7;

  // Control store addresses
  localparam logic [PC_W-1:0] PC_FINISH     = 4'd0;
  localparam logic [PC_W-1:0] PC_CLR_GATE   = 4'd1;
  localparam logic [PC_W-1:0] PC_CLR_SEARCH = 4'd2;
  localparam logic [PC_W-1:0] PC_CLR_FOUND  = 4'd3;
  localparam logic [PC_W-1:0] PC_CLR_SHIFT  = 4'd4;
  localparam logic [PC_W-1:0] PC_CLR_DROP   = 4'd5;
  localparam logic [PC_W-1:0] PC_SET_GATE   = 4'd6;
  localparam logic [PC_W-1:0] PC_SET_APPEND = 4'd7;
  localparam logic [PC_W-1:0] PC_ROT_INC    = 4'd8;
  localparam logic [PC_W-1:0] PC_ROT_WRAP   = 4'd9;
  localparam logic [PC_W-1:0] PC_ROT_LOAD   = 4'd10;
  localparam logic [PC_W-1:0] PC_SCAN       = 4'd11;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [3:0]        op_t;
  typedef logic [2:0]        cond_t;
  typedef logic [PC_W-1:0]   pc_t;

  typedef struct packed {
    code_t           dot;
    code_t [3:0]     ch;
  } text_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [KIND_W-1:0] message_kind;
    logic [7:0]        switch_inputs;
  } cmd_t;

  typedef struct packed {
    logic [7:0] segment_byte;
    logic [7:0] digit_select;
    logic [7:0] relay_byte;
    logic [3:0] message_count;
    logic [3:0] shown_slot;
  } result_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  hold;   // stay on this word while the jump is not taken
    logic  gated;  // perform the operation only while the jump is not taken
    logic  last;
  } ucode_t;

  typedef struct packed {
    logic clr_skip;
    logic match_or_end;
    logic ptr_end;
    logic shift_end;
    logic set_skip;
    logic empty;
    logic idx_lt;
  } cond_flags_t;

  typedef struct packed {
    op_t  op;
    logic run;
    logic finish;
  } ctrl_t;

  function automatic text_t mk_text(input code_t c0, input code_t c1,
                                    input code_t c2, input code_t c3);
    text_t t;
    t.ch[0] = c0;
    t.ch[1] = c1;
    t.ch[2] = c2;
    t.ch[3] = c3;
    t.dot   = '0;
    return t;
  endfunction

  function automatic text_t text_rom(input logic [KIND_W-1:0] kind);
    text_t t;
    case (kind)
      5'd0:    t = mk_text(5'd28, 5'd27, 5'd27, 5'd28);
      5'd1:    t = mk_text(5'd10, 5'd26, 5'd25, 5'd22);
      5'd2:    t = mk_text(5'd23, 5'd27, 5'd1,  5'd10);
      5'd3:    t = mk_text(5'd23, 5'd27, 5'd2,  5'd10);
      5'd4:    t = mk_text(5'd23, 5'd27, 5'd3,  5'd10);
      5'd5:    t = mk_text(5'd23, 5'd27, 5'd1,  5'd17);
      5'd6:    t = mk_text(5'd23, 5'd27, 5'd2,  5'd17);
      5'd7:    t = mk_text(5'd23, 5'd27, 5'd3,  5'd17);
      5'd8:    t = mk_text(5'd23, 5'd1,  5'd28, 5'd26);
      5'd9:    t = mk_text(5'd23, 5'd2,  5'd28, 5'd26);
      5'd10:   t = mk_text(5'd23, 5'd3,  5'd28, 5'd26);
      5'd11:   t = mk_text(5'd23, 5'd1,  5'd28, 5'd21);
      5'd12:   t = mk_text(5'd23, 5'd2,  5'd28, 5'd21);
      5'd13:   t = mk_text(5'd23, 5'd3,  5'd28, 5'd21);
      5'd14:   t = mk_text(5'd10, 5'd19, 5'd28, 5'd26);
      5'd15:   t = mk_text(5'd10, 5'd19, 5'd28, 5'd21);
      5'd16:   t = mk_text(5'd25, 5'd1,  5'd28, 5'd26);
      5'd17:   t = mk_text(5'd25, 5'd1,  5'd28, 5'd21);
      5'd18:   t = mk_text(5'd25, 5'd2,  5'd28, 5'd26);
      5'd19:   t = mk_text(5'd25, 5'd2,  5'd28, 5'd21);
      5'd20:   t = mk_text(5'd15, 5'd24, 5'd24, 5'd28);
      5'd21:   t = mk_text(5'd28, 5'd27, 5'd27, 5'd28);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] seg_rom(input code_t code);
    logic [7:0] s;
    case (code)
      5'd0:    s = 8'h3f;
      5'd1:    s = 8'h06;
      5'd2:    s = 8'h5b;
      5'd3:    s = 8'h4f;
      5'd4:    s = 8'h66;
      5'd5:    s = 8'h6d;
      5'd6:    s = 8'h7d;
      5'd7:    s = 8'h07;
      5'd8:    s = 8'h7f;
      5'd9:    s = 8'h6f;
      5'd10:   s = 8'h77;
      5'd11:   s = 8'h7c;
      5'd12:   s = 8'h39;
      5'd13:   s = 8'h58;
      5'd14:   s = 8'h5e;
      5'd15:   s = 8'h79;
      5'd16:   s = 8'h71;
      5'd17:   s = 8'h76;
      5'd18:   s = 8'h74;
      5'd19:   s = 8'h38;
      5'd20:   s = 8'h54;
      5'd21:   s = 8'h37;
      5'd22:   s = 8'h5c;
      5'd23:   s = 8'h73;
      5'd24:   s = 8'h50;
      5'd25:   s = 8'h78;
      5'd26:   s = 8'h3e;
      5'd27:   s = 8'h40;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] sel_rom(input logic [1:0] d);
    logic [7:0] s;
    case (d)
      2'd0:    s = 8'hFE;
      2'd1:    s = 8'hFD;
      2'd2:    s = 8'hFB;
      default: s = 8'hF7;
    endcase
    return s;
  endfunction

  function automatic pc_t entry_pc(input logic [1:0] action);
    pc_t p;
    case (action)
      ACT_SET:    p = PC_SET_GATE;
      ACT_CLEAR:  p = PC_CLR_GATE;
      ACT_ROTATE: p = PC_ROT_INC;
      default:    p = PC_SCAN;
    endcase
    return p;
  endfunction

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      PC_FINISH:     w = '{OP_NOP,      CND_NEVER,        PC_FINISH,    1'b0, 1'b0, 1'b1};
      PC_CLR_GATE:   w = '{OP_PTR_ZERO, CND_CLR_SKIP,     PC_FINISH,    1'b0, 1'b0, 1'b0};
      PC_CLR_SEARCH: w = '{OP_PTR_INC,  CND_MATCH_OR_END, PC_CLR_FOUND, 1'b1, 1'b1, 1'b0};
      PC_CLR_FOUND:  w = '{OP_NOP,      CND_PTR_END,      PC_FINISH,    1'b0, 1'b0, 1'b0};
      PC_CLR_SHIFT:  w = '{OP_SHIFT,    CND_SHIFT_END,    PC_CLR_DROP,  1'b1, 1'b1, 1'b0};
      PC_CLR_DROP:   w = '{OP_REMOVE,   CND_NEVER,        PC_FINISH,    1'b0, 1'b0, 1'b1};
      PC_SET_GATE:   w = '{OP_NOP,      CND_SET_SKIP,     PC_FINISH,    1'b0, 1'b0, 1'b0};
      PC_SET_APPEND: w = '{OP_APPEND,   CND_NEVER,        PC_FINISH,    1'b0, 1'b0, 1'b1};
      PC_ROT_INC:    w = '{OP_IDX_INC,  CND_EMPTY,        PC_FINISH,    1'b0, 1'b1, 1'b0};
      PC_ROT_WRAP:   w = '{OP_IDX_SUB,  CND_IDX_LT,       PC_ROT_LOAD,  1'b1, 1'b1, 1'b0};
      PC_ROT_LOAD:   w = '{OP_LOAD,     CND_NEVER,        PC_FINISH,    1'b0, 1'b0, 1'b1};
      PC_SCAN:       w = '{OP_SCAN,     CND_NEVER,        PC_FINISH,    1'b0, 1'b0, 1'b1};
      default:       w = '{OP_NOP,      CND_NEVER,        PC_FINISH,    1'b0, 1'b0, 1'b1};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/smrds_seq.sv
// ----------------------------------------------------------------------------
// smrds_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module smrds_seq
  import smrds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [1:0]  action,
  input  cond_flags_t flags,
  output ctrl_t       ctrl,
  output logic        busy
);

  pc_t    pc;
  logic   running;
  logic   flush;
  ucode_t word;
  logic   taken;

  assign word = ucode_rom(pc);

  always_comb begin
    case (word.cond)
      CND_CLR_SKIP:     taken = flags.clr_skip;
      CND_MATCH_OR_END: taken = flags.match_or_end;
      CND_PTR_END:      taken = flags.ptr_end;
      CND_SHIFT_END:    taken = flags.shift_end;
      CND_SET_SKIP:     taken = flags.set_skip;
      CND_EMPTY:        taken = flags.empty;
      CND_IDX_LT:       taken = flags.idx_lt;
      default:          taken = 1'b0;
    endcase
  end

  assign ctrl.op     = word.op;
  assign ctrl.run    = running && !(word.gated && taken);
  assign ctrl.finish = flush;
  assign busy        = running || flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      flush   <= 1'b0;
      pc      <= PC_FINISH;
    end else begin
      flush <= 1'b0;
      if (go) begin
        running <= 1'b1;
        pc      <= entry_pc(action);
      end else if (running) begin
        if (word.last) begin
          running <= 1'b0;
          flush   <= 1'b1;
        end else if (taken) begin
          pc <= word.target;
        end else if (!word.hold) begin
          pc <= pc + 1'b1;
        end
      end
    end
  end

  // Running and result flush never overlap.
  a_run_flush_excl: assert property (@(posedge clk) disable iff (rst)
    !(running && flush)) else $error("sequencer running during flush");

  // A program always ends in a flush the cycle after its last word.
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    running && word.last |=> flush && !running) else $error("last word without flush");

  // The step counter stays inside the control store while running.
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    running |-> pc <= PC_SCAN) else $error("step counter out of range");

endmodule

FILE: hdl/status_message_rotator_display_scan.sv
// ----------------------------------------------------------------------------
// status_message_rotator_display_scan
// Active status message list with rotation onto a four-digit seven-segment
// display and a multiplexed digit scan.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                 Handshake
//  --------  --------------------  ---------------------------------------
//  command   cmd, start, busy      item taken on clk when start && !busy
//  result    result, done          one-cycle strobe, receiver always takes
//
//  Rotate adds wrap subtractions and clear walks the list, as the
//  microcode loops walk the list one slot per cycle through one port.
//  Reset (rst, synchronous) empties the list and clears the shown position,
//  the shown text and the scan digit; no clearing pass is needed.
//  busy holds from acceptance until the result strobe rises; never stalled.
// ----------------------------------------------------------------------------
module status_message_rotator_display_scan
  import smrds_pkg::*;
#(
  parameter int LIST_DEPTH    = 10,
  parameter int MESSAGE_KINDS = 22
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int SLOT_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // Control state
  logic [MESSAGE_KINDS-1:0] mask;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         idx;
  text_t                    digits;
  logic [1:0]               scan_digit;

  // Item and working registers
  cmd_t                     item;
  logic [CNT_W-1:0]         ptr;
  logic [7:0]               seg;
  logic [7:0]               sel;
  logic [7:0]               relay;

  // List storage: one kind per slot, written only at or below the fill count
  logic [KIND_W-1:0]        slots [LIST_DEPTH];

  logic                     accept;
  ctrl_t                    ctrl;
  cond_flags_t              flags;
  logic [MESSAGE_KINDS-1:0] kind_hot;
  logic                     kind_ok;
  logic                     mask_hit;
  logic [CNT_W-1:0]         ptr_inc;
  logic [SLOT_W-1:0]        rd_addr;
  logic [KIND_W-1:0]        slot_rd;
  logic                     match;
  logic [7:0]               seg_next;

  assign accept = start && !busy;

  smrds_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .go     (accept),
    .action (cmd.action),
    .flags  (flags),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // Decode the item's kind once: one-hot against the active mask.
  always_comb begin
    for (int k = 0; k < MESSAGE_KINDS; k++) begin
      kind_hot[k] = (item.message_kind == KIND_W'(k));
    end
  end

  assign kind_ok  = ({1'b0, item.message_kind} < (KIND_W + 1)'(MESSAGE_KINDS)) &&
                    (item.message_kind < KIND_W'(TEXT_KINDS));
  assign mask_hit = |(mask & kind_hot);
  assign ptr_inc  = ptr + 1'b1;

  // Single read port: search reads at the pointer, the gap close reads one
  // slot ahead, the rotate load reads the shown slot.
  always_comb begin
    case (ctrl.op)
      OP_SHIFT: rd_addr = ptr_inc[SLOT_W-1:0];
      OP_LOAD:  rd_addr = idx[SLOT_W-1:0];
      default:  rd_addr = ptr[SLOT_W-1:0];
    endcase
  end

  assign slot_rd = slots[rd_addr];
  // Compare texts, not kinds: two kinds share one text.
  assign match   = (text_rom(slot_rd) == text_rom(item.message_kind));

  assign flags.clr_skip     = !kind_ok || !mask_hit;
  assign flags.ptr_end      = (ptr >= count);
  assign flags.match_or_end = flags.ptr_end || match;
  assign flags.shift_end    = (ptr_inc >= count);
  assign flags.set_skip     = !kind_ok || mask_hit || (count == CNT_W'(LIST_DEPTH));
  assign flags.empty        = (count == '0);
  assign flags.idx_lt       = (idx < count);

  // Segment pattern of the digit being scanned, with the dot where marked.
  always_comb begin
    seg_next = seg_rom(digits.ch[scan_digit]);
    if (digits.dot == (CODE_W'(scan_digit) + 1'b1)) begin
      seg_next = seg_next | DOT_BIT;
    end
  end

  // List storage writes: append at the fill count, or pull the next slot
  // down while closing a gap.
  always_ff @(posedge clk) begin
    if (ctrl.run) begin
      case (ctrl.op)
        OP_APPEND: slots[count[SLOT_W-1:0]] <= item.message_kind;
        OP_SHIFT:  slots[ptr[SLOT_W-1:0]]   <= slot_rd;
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mask       <= '0;
      count      <= '0;
      idx        <= '0;
      digits     <= '0;
      scan_digit <= '0;
      done       <= 1'b0;
    end else begin
      done <= ctrl.finish;
      if (ctrl.run) begin
        case (ctrl.op)
          OP_APPEND: begin
            count <= count + 1'b1;
            mask  <= mask | kind_hot;
          end
          OP_REMOVE: begin
            count <= count - 1'b1;
            mask  <= mask & ~kind_hot;
          end
          OP_IDX_INC: idx <= idx + 1'b1;
          OP_IDX_SUB: idx <= idx - count;
          OP_LOAD: begin
            if (slot_rd < KIND_W'(TEXT_KINDS)) begin
              digits <= text_rom(slot_rd);
            end
          end
          OP_SCAN: scan_digit <= scan_digit + 1'b1;
          default: begin
          end
        endcase
      end
    end
  end

  // Item, pointer and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item  <= cmd;
      seg   <= '0;
      sel   <= SEL_NONE;
      relay <= '0;
    end else if (ctrl.run) begin
      case (ctrl.op)
        OP_PTR_ZERO: ptr <= '0;
        OP_PTR_INC:  ptr <= ptr_inc;
        OP_SHIFT:    ptr <= ptr_inc;
        OP_SCAN: begin
          seg   <= seg_next;
          sel   <= sel_rom(scan_digit);
          relay <= ~item.switch_inputs;
        end
        default: begin
        end
      endcase
    end
    // Capture the result after the last step has settled the list.
    if (ctrl.finish) begin
      result.segment_byte  <= seg;
      result.digit_select  <= sel;
      result.relay_byte    <= relay;
      result.message_count <= 4'(count);
      result.shown_slot    <= 4'(idx);
    end
  end

  // The number of active kinds equals the fill count.
  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    $countones(mask) == 32'(count)) else $error("active mask and count disagree");

  // A result strobe follows only the sequencer's flush cycle.
  a_done_after_flush: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctrl.finish)) else $error("result strobe without flush");

  // One result per item: the strobe is never held high.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held");

  // The fill count never passes the list depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIST_DEPTH)) else $error("list overfilled");

endmodule

FILE: tb/status_message_rotator_display_scan_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_message_rotator_display_scan_test
// Self-checking bench for the status message rotator. A scoreboard class keeps
// its own copy of the message list, shown text and scan digit. It predicts one
// result per accepted item and checks every strobed result against the oldest
// prediction. Directed items come first, then biased random traffic with
// random sender gaps.
// ----------------------------------------------------------------------------
module status_message_rotator_display_scan_test;
  import smrds_pkg::*;

  localparam int SLOTS       = 10;
  localparam int KIND_COUNT  = 22;
  localparam int RAND_ITEMS  = 1450;
  localparam int QUIET_TAIL  = 150;     // final items sent back to back
  localparam int CYCLE_LIMIT = 400000;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the display state and holds due results in order
  // --------------------------------------------------------------------------
  class display_scoreboard;
    logic [4:0] msg_text [KIND_COUNT][5];
    logic [7:0] seg_of [29];
    logic [4:0] list_kinds [SLOTS];
    logic [31:0] active_bits;
    int          list_len;
    int          shown_pos;
    logic [4:0]  shown_text [5];
    logic [1:0]  next_digit;
    result_t     due_results [$];
    int          fail_count;

    function new();
      msg_text = '{
        '{28, 27, 27, 28, 0}, '{10, 26, 25, 22, 0}, '{23, 27, 1, 10, 0},
        '{23, 27, 2, 10, 0},  '{23, 27, 3, 10, 0},  '{23, 27, 1, 17, 0},
        '{23, 27, 2, 17, 0},  '{23, 27, 3, 17, 0},  '{23, 1, 28, 26, 0},
        '{23, 2, 28, 26, 0},  '{23, 3, 28, 26, 0},  '{23, 1, 28, 21, 0},
        '{23, 2, 28, 21, 0},  '{23, 3, 28, 21, 0},  '{10, 19, 28, 26, 0},
        '{10, 19, 28, 21, 0}, '{25, 1, 28, 26, 0},  '{25, 1, 28, 21, 0},
        '{25, 2, 28, 26, 0},  '{25, 2, 28, 21, 0},  '{15, 24, 24, 28, 0},
        '{28, 27, 27, 28, 0}
      };
      seg_of = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
        8'h77, 8'h7c, 8'h39, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h76, 8'h74, 8'h38,
        8'h54, 8'h37, 8'h5c, 8'h73, 8'h50, 8'h78, 8'h3e, 8'h40, 8'h00
      };
      // Reset state: empty list, zero codes shown, scan on digit 0
      foreach (list_kinds[i]) list_kinds[i] = '0;
      foreach (shown_text[i]) shown_text[i] = '0;
      active_bits = '0;
      list_len    = 0;
      shown_pos   = 0;
      next_digit  = '0;
      fail_count  = 0;
    endfunction

    function bit same_text(int a, int b);
      bit eq;
      eq = 1'b1;
      for (int i = 0; i < 5; i++)
        if (msg_text[a][i] != msg_text[b][i]) eq = 1'b0;
      return eq;
    endfunction

    // Advance the predicted state by one accepted item and queue its result
    function void note_item(cmd_t c);
      result_t    r;
      int         k;
      bit         hit;
      logic [1:0] d;
      logic [4:0] code;
      k = c.message_kind;
      r.segment_byte = '0;
      r.digit_select = SEL_NONE;
      r.relay_byte   = '0;
      case (c.action)
        ACT_SET: begin
          if (k < KIND_COUNT && !active_bits[k] && list_len < SLOTS) begin
            list_kinds[list_len] = c.message_kind;
            list_len++;
            active_bits[k] = 1'b1;
          end
        end
        ACT_CLEAR: begin
          // Remove the first entry sharing the text; drop only the named bit
          if (k < KIND_COUNT && active_bits[k]) begin
            hit = 1'b0;
            for (int i = 0; i < list_len && !hit; i++) begin
              if (same_text(list_kinds[i], k)) begin
                for (int j = i; j + 1 < list_len; j++) list_kinds[j] = list_kinds[j + 1];
                list_len--;
                active_bits[k] = 1'b0;
                hit = 1'b1;
              end
            end
          end
        end
        ACT_ROTATE: begin
          // An empty list holds the display
          if (list_len != 0) begin
            shown_pos = (shown_pos + 1) % list_len;
            for (int i = 0; i < 5; i++) shown_text[i] = msg_text[list_kinds[shown_pos]][i];
          end
        end
        default: begin
          d    = next_digit;
          code = shown_text[d];
          r.segment_byte = (code < 29) ? seg_of[code] : 8'h00;
          if (int'(shown_text[4]) == int'(d) + 1) r.segment_byte |= DOT_BIT;
          r.digit_select = ~(8'h01 << d);
          r.relay_byte   = ~c.switch_inputs;
          next_digit     = d + 2'd1;
        end
      endcase
      r.message_count = list_len[3:0];
      r.shown_slot    = shown_pos[3:0];
      due_results.push_back(r);
    endfunction

    task report(string what);
      if (fail_count < 40) $display("mismatch: %s", what);
      fail_count++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %h with nothing due", got));
      end else begin
        want = due_results.pop_front();
        if (got.segment_byte !== want.segment_byte)
          report($sformatf("segment_byte %h, due %h", got.segment_byte, want.segment_byte));
        if (got.digit_select !== want.digit_select)
          report($sformatf("digit_select %h, due %h", got.digit_select, want.digit_select));
        if (got.relay_byte !== want.relay_byte)
          report($sformatf("relay_byte %h, due %h", got.relay_byte, want.relay_byte));
        if (got.message_count !== want.message_count)
          report($sformatf("message_count %0d, due %0d", got.message_count,
                           want.message_count));
        if (got.shown_slot !== want.shown_slot)
          report($sformatf("shown_slot %0d, due %0d", got.shown_slot, want.shown_slot));
      end
    endtask

    function int pending();
      return due_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;

  display_scoreboard sb;
  int cycle_count = 0;
  int idle_rate;

  always #6 clk = ~clk;

  status_message_rotator_display_scan dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // Watch both channels on the clock edge: check the strobed result first,
  // then note the item taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_item(cmd);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic cmd_t mk(logic [1:0] act, int kind, int sw);
    cmd_t c;
    c.action        = act;
    c.message_kind  = kind[4:0];
    c.switch_inputs = sw[7:0];
    return c;
  endfunction

  // Offer one item and hold it until the block takes it. A random idle
  // gap may come first, at the rate set by idle_rate.
  task automatic push_item(cmd_t c);
    int gap;
    if (idle_rate > 0 && $urandom_range(0, 3) < idle_rate) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random item: set_share steers the list between filling and draining
  function automatic cmd_t rand_item(int set_share);
    int         pick;
    int         kind;
    logic [1:0] act;
    pick = $urandom_range(0, 99);
    if (pick < set_share)           act = ACT_SET;
    else if (pick < 55)             act = ACT_CLEAR;
    else if (pick < 75)             act = ACT_ROTATE;
    else                            act = ACT_SCAN;
    pick = $urandom_range(0, 99);
    if (pick < 10)      kind = $urandom_range(KIND_COUNT, 31);
    else if (pick < 25) kind = ($urandom_range(0, 1) != 0) ? 21 : 0;
    else                kind = $urandom_range(0, KIND_COUNT - 1);
    return mk(act, kind, $urandom_range(0, 255));
  endfunction

  initial begin
    int set_share;
    sb = new();
    idle_rate = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: scans and rotate on an empty list, out-of-range kinds,
    // clear of an inactive kind, the shared text of kinds 0 and 21,
    // set of an active kind, a full list.
    push_item(mk(ACT_SCAN, 0, 8'h00));
    push_item(mk(ACT_SCAN, 31, 8'hFF));
    push_item(mk(ACT_ROTATE, 0, 8'h00));
    push_item(mk(ACT_SET, 31, 8'h00));
    push_item(mk(ACT_SET, KIND_COUNT, 8'h00));
    push_item(mk(ACT_CLEAR, 5, 8'h00));
    push_item(mk(ACT_SET, 21, 8'h00));
    push_item(mk(ACT_SET, 0, 8'h00));
    push_item(mk(ACT_SET, 21, 8'h00));
    push_item(mk(ACT_ROTATE, 0, 8'h00));
    push_item(mk(ACT_SCAN, 0, 8'hA5));
    push_item(mk(ACT_SCAN, 0, 8'h5A));
    for (int k = 1; k <= 9; k++) push_item(mk(ACT_SET, k, 8'h00));
    push_item(mk(ACT_CLEAR, 0, 8'h00));
    push_item(mk(ACT_CLEAR, 31, 8'h00));
    push_item(mk(ACT_ROTATE, 0, 8'h00));
    push_item(mk(ACT_CLEAR, 21, 8'h00));

    // Random: change the mix every hundred items; no gaps in the tail
    set_share = 30;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        set_share = $urandom_range(15, 45);
        idle_rate = $urandom_range(0, 3);
      end
      if (n >= RAND_ITEMS - QUIET_TAIL) idle_rate = 0;
      push_item(rand_item(set_share));
    end
    start <= 1'b0;

    // Drain outstanding results, then allow for a stray strobe
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/smrds_pkg.sv
hdl/smrds_seq.sv
hdl/status_message_rotator_display_scan.sv
tb/status_message_rotator_display_scan_test.sv
